/* rtl/r2nv_pkg.sv */
package r2nv_pkg;

	// Frame geometry limits.
	localparam int MAX_WIDTH  = 4096;
	localparam int MAX_HEIGHT = 4096;
	localparam int MIN_DIM    = 16;

	// Configuration register width and counter widths.
	localparam int DIM_W = 13;
	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int ROW_W = $clog2(MAX_HEIGHT);

	// One line buffer entry per horizontal pixel pair.
	localparam int LINE_DEPTH = MAX_WIDTH / 2;
	localparam int LINE_AW    = $clog2(LINE_DEPTH);

	// Per-pixel chroma term and packed pair sum (U in the low half, V above).
	localparam int TERM_W = 9;
	localparam int PAIR_W = 2 * TERM_W;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'd1;

	localparam logic [DIM_W-1:0] WIDTH_RESET  = 13'd1920;
	localparam logic [DIM_W-1:0] HEIGHT_RESET = 13'd1080;

	// Position of a pixel within its frame, as the chroma logic needs it.
	typedef struct packed {
		logic               col_odd;
		logic               row_odd;
		logic               frame_end;
		logic [LINE_AW-1:0] idx;
	} pos_t;

	// Line buffer write request.
	typedef struct packed {
		logic               en;
		logic [LINE_AW-1:0] addr;
		logic [PAIR_W-1:0]  data;
	} line_wr_t;

endpackage

/* rtl/r2nv_position.sv */
module r2nv_position import r2nv_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DIM_W-1:0]     cfg_data,
	input  logic                 advance,
	output pos_t                 pos
);

	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [DIM_W-1:0] col_nxt;
	logic [DIM_W-1:0] row_nxt;

	// Round down to even, then saturate into the supported range.
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d,
	                                               input logic [DIM_W-1:0] maxv);
		logic [DIM_W-1:0] v;
		v = {d[DIM_W-1:1], 1'b0};
		if (v < DIM_W'(MIN_DIM))
			return DIM_W'(MIN_DIM);
		else if (v > maxv)
			return maxv;
		else
			return v;
	endfunction

	assign col_nxt = DIM_W'(col_q) + 1'b1;
	assign row_nxt = DIM_W'(row_q) + 1'b1;

	assign pos.col_odd   = col_q[0];
	assign pos.row_odd   = row_q[0];
	assign pos.idx       = col_q[COL_W-1:1];
	assign pos.frame_end = (DIM_W'(row_q) == height_q - 1'b1) &&
	                       (DIM_W'(col_q) == width_q - 1'b1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_FRAME_WIDTH:  width_q  <= clamp_dim(cfg_data, DIM_W'(MAX_WIDTH));
				CFG_FRAME_HEIGHT: height_q <= clamp_dim(cfg_data, DIM_W'(MAX_HEIGHT));
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (advance) begin
			if (col_nxt >= width_q) begin
				col_q <= '0;
				row_q <= (row_nxt >= height_q) ? '0 : row_nxt[ROW_W-1:0];
			end else begin
				col_q <= col_nxt[COL_W-1:0];
			end
		end
	end

endmodule

/* rtl/r2nv_line_mem.sv */
module r2nv_line_mem import r2nv_pkg::*; (
	input  logic               clk,
	input  logic               rd_en,
	input  logic [LINE_AW-1:0] rd_addr,
	output logic [PAIR_W-1:0]  rd_data,
	input  line_wr_t           wr
);

	logic [PAIR_W-1:0] mem [LINE_DEPTH];

	always_ff @(posedge clk) begin
		if (wr.en)
			mem[wr.addr] <= wr.data;
		if (rd_en)
			rd_data <= mem[rd_addr];
	end

endmodule

/* rtl/r2nv_csc.sv */
module r2nv_csc import r2nv_pkg::*; (
	input  logic              clk,
	input  logic              en,
	input  logic [7:0]        red,
	input  logic [7:0]        green,
	input  logic [7:0]        blue,
	output logic [7:0]        luma_s2,
	output logic [TERM_W-1:0] cb_s2,
	output logic [TERM_W-1:0] cr_s2
);

	logic [15:0] y_sum;
	logic [8:0]  y_off;
	logic [15:0] u_sum;
	logic [15:0] v_sum;

	// All three sums stay non-negative (the chroma sums thanks to the 128*256
	// bias), so plain unsigned arithmetic gives the floor shift.
	assign y_sum = 16'(16'd66 * red) + 16'(16'd129 * green) + 16'(16'd25 * blue) + 16'd128;
	assign y_off = 9'(y_sum[15:8]) + 9'd16;
	assign u_sum = 16'd32896 + 16'(16'd112 * blue) - 16'(16'd38 * red) - 16'(16'd74 * green);
	assign v_sum = 16'd32896 + 16'(16'd112 * red) - 16'(16'd94 * green) - 16'(16'd18 * blue);

	always_ff @(posedge clk) begin
		if (en) begin
			luma_s2 <= y_off[8] ? 8'hFF : y_off[7:0];
			cb_s2   <= TERM_W'(u_sum[15:8]);
			cr_s2   <= TERM_W'(v_sum[15:8]);
		end
	end

endmodule

/* rtl/r2nv_chroma.sv */
module r2nv_chroma import r2nv_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              commit,
	input  pos_t              pos,
	input  logic [TERM_W-1:0] cb,
	input  logic [TERM_W-1:0] cr,
	input  logic [PAIR_W-1:0] line,
	output line_wr_t          wr,
	output logic              chroma_valid,
	output logic [7:0]        chroma_u,
	output logic [7:0]        chroma_v
);

	logic [PAIR_W-1:0] pair_sum_q;
	logic [PAIR_W-1:0] packed_uv;
	logic [PAIR_W-1:0] pair;
	logic [TERM_W:0]   su;
	logic [TERM_W:0]   sv;

	assign packed_uv = {cr, cb};
	assign pair      = pair_sum_q + packed_uv;

	assign su = (TERM_W+1)'(line[TERM_W-1:0]) + (TERM_W+1)'(pair[TERM_W-1:0]);
	assign sv = (TERM_W+1)'(line[PAIR_W-1:TERM_W]) + (TERM_W+1)'(pair[PAIR_W-1:TERM_W]);

	// The sum of four 8-bit values shifted by two always fits eight bits.
	assign chroma_valid = pos.col_odd && pos.row_odd;
	assign chroma_u     = chroma_valid ? su[TERM_W:2] : 8'd0;
	assign chroma_v     = chroma_valid ? sv[TERM_W:2] : 8'd0;

	assign wr.en   = commit && pos.col_odd && !pos.row_odd;
	assign wr.addr = pos.idx;
	assign wr.data = pair;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pair_sum_q <= '0;
		else if (commit && !pos.col_odd)
			pair_sum_q <= packed_uv;
	end

endmodule

/* rtl/rgba_to_nv12_converter.sv */
// RGB to NV12 pixel converter, BT.601 integer coefficients, 4:2:0 chroma.
//
// Pixels enter on the pixel channel (pixel_valid / pixel_ready) in raster
// order, one beat per pixel with red, green and blue. Every input beat gives
// exactly one beat on the result channel (result_valid / result_ready): the
// clamped luma of that pixel, and on the odd-row, odd-column pixel of each
// 2x2 block the averaged chroma_u / chroma_v with chroma_valid set.
// frame_end marks the last pixel of the frame.
//
// The path is three registers deep: input stage with the line buffer read,
// color conversion stage, and the result register. One pixel is taken per
// clock while the receiver does not stall. The line buffer is a single
// memory of one entry per pixel pair, written on even rows; it is read for
// every pixel, and its data is used one row later on odd rows.
//
// When the receiver stalls, the pipeline keeps accepting pixels until every
// stage holds one, then drops pixel_ready. Reset clears the pixel position to
// the top-left corner and sets the frame to 1920 by 1080; the user must write
// width and height on the cfg port only while no pixel is in flight, unchecked.
module rgba_to_nv12_converter import r2nv_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DIM_W-1:0]     cfg_data,
	input  logic                 pixel_valid,
	output logic                 pixel_ready,
	input  logic [7:0]           red,
	input  logic [7:0]           green,
	input  logic [7:0]           blue,
	output logic                 result_valid,
	input  logic                 result_ready,
	output logic [7:0]           luma,
	output logic                 chroma_valid,
	output logic [7:0]           chroma_u,
	output logic [7:0]           chroma_v,
	output logic                 frame_end
);

	logic              accept;
	logic              en1;
	logic              en2;
	logic              en_o;
	pos_t              pos_cur;
	logic              v_s1;
	logic              v_s2;
	pos_t              pos_s1;
	pos_t              pos_s2;
	logic [7:0]        red_s1;
	logic [7:0]        green_s1;
	logic [7:0]        blue_s1;
	logic [PAIR_W-1:0] line_s1;
	logic [PAIR_W-1:0] line_s2;
	logic [7:0]        luma_s2;
	logic [TERM_W-1:0] cb_s2;
	logic [TERM_W-1:0] cr_s2;
	line_wr_t          line_wr;
	logic              chr_valid;
	logic [7:0]        chr_u;
	logic [7:0]        chr_v;
	logic              result_valid_q;
	logic [7:0]        luma_q;
	logic              chroma_valid_q;
	logic [7:0]        chroma_u_q;
	logic [7:0]        chroma_v_q;
	logic              frame_end_q;

	// Each stage moves forward when the one after it is empty or moving.
	assign en_o        = !result_valid_q || result_ready;
	assign en2         = !v_s2 || en_o;
	assign en1         = !v_s1 || en2;
	assign pixel_ready = en1;
	assign accept      = pixel_valid && pixel_ready;

	r2nv_position u_position (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.advance   (accept),
		.pos       (pos_cur)
	);

	// The line buffer is read as the pixel enters, so its data lines up with
	// the first stage. A writer of the same entry is a full row ahead and has
	// long left the pipeline.
	r2nv_line_mem u_line_mem (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (pos_cur.idx),
		.rd_data (line_s1),
		.wr      (line_wr)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en1)
				v_s1 <= accept;
			if (en2)
				v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			red_s1   <= red;
			green_s1 <= green;
			blue_s1  <= blue;
			pos_s1   <= pos_cur;
		end
		if (en2 && v_s1) begin
			pos_s2  <= pos_s1;
			line_s2 <= line_s1;
		end
	end

	r2nv_csc u_csc (
		.clk     (clk),
		.en      (en2 && v_s1),
		.red     (red_s1),
		.green   (green_s1),
		.blue    (blue_s1),
		.luma_s2 (luma_s2),
		.cb_s2   (cb_s2),
		.cr_s2   (cr_s2)
	);

	r2nv_chroma u_chroma (
		.clk          (clk),
		.arst_n       (arst_n),
		.commit       (en_o && v_s2),
		.pos          (pos_s2),
		.cb           (cb_s2),
		.cr           (cr_s2),
		.line         (line_s2),
		.wr           (line_wr),
		.chroma_valid (chr_valid),
		.chroma_u     (chr_u),
		.chroma_v     (chr_v)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			result_valid_q <= 1'b0;
		else if (en_o)
			result_valid_q <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (en_o && v_s2) begin
			luma_q         <= luma_s2;
			chroma_valid_q <= chr_valid;
			chroma_u_q     <= chr_u;
			chroma_v_q     <= chr_v;
			frame_end_q    <= pos_s2.frame_end;
		end
	end

	assign result_valid = result_valid_q;
	assign luma         = luma_q;
	assign chroma_valid = chroma_valid_q;
	assign chroma_u     = chroma_u_q;
	assign chroma_v     = chroma_v_q;
	assign frame_end    = frame_end_q;

`ifndef SYNTHESIS
	// The line buffer is written only from even rows, never by a pixel that
	// emits chroma.
	a_wr_even_row: assert property (@(posedge clk) disable iff (!arst_n)
		line_wr.en |-> !pos_s2.row_odd && !chr_valid)
		else $error("line buffer written from an odd row");

	// With every stage full and the receiver stalled, no pixel may enter.
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && v_s2 && result_valid && !result_ready) |-> !pixel_ready)
		else $error("pixel accepted into a full pipeline");

	// After the last pixel of a frame the position returns to the origin.
	a_frame_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && pos_cur.frame_end) |=>
			(pos_cur.idx == '0 && !pos_cur.col_odd && !pos_cur.row_odd))
		else $error("position did not wrap after frame end");

	// A stalled result keeps its chroma marker and frame end.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result_ready) |=> $stable(chroma_valid) && $stable(frame_end))
		else $error("result changed while stalled");
`endif

endmodule
